// ===== rtl/core/caps_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package caps_pkg;

  // Coordinate, matrix and level formats.
  localparam int COORD_W = 24;
  localparam int MAT_W   = 20;
  localparam int LVL_W   = 3;
  localparam int FAC_W   = 16;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [MAT_W-1:0]   mat_t;
  typedef logic [LVL_W-1:0]          lvl_t;
  typedef logic [FAC_W-1:0]          factor_t;

  // Arc kinds select the row of the chord factor table.
  localparam logic KIND_QUARTER = 1'b0;
  localparam logic KIND_HALF    = 1'b1;

  // Sequencer states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_MUL,
    S_PUSH,
    S_DONE
  } state_t;

  // Steps of the multiply sequence for one axis.
  typedef enum logic [2:0] {
    MS_P0,
    MS_P1,
    MS_SUM,
    MS_FLO,
    MS_FHI,
    MS_ACC,
    MS_ADD
  } mstep_t;

  // Chord factors, 0.5*tan(angle/4) with 16 fraction bits. A half arc
  // starts one level earlier in the same halving sequence.
  function automatic factor_t chord_factor(input logic kind, input lvl_t lvl);
    factor_t q;
    case (lvl)
      3'd0:    q = 16'd13573;
      3'd1:    q = 16'd6518;
      3'd2:    q = 16'd3227;
      3'd3:    q = 16'd1610;
      3'd4:    q = 16'd804;
      default: q = 16'd402;
    endcase
    if (kind == KIND_HALF) begin
      case (lvl)
        3'd0:    q = 16'd32768;
        3'd1:    q = 16'd13573;
        3'd2:    q = 16'd6518;
        3'd3:    q = 16'd3227;
        3'd4:    q = 16'd1610;
        default: q = 16'd804;
      endcase
    end
    return q;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/conic_arc_polyline_subdivider_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel  Direction  Ports                                         Contents
// in       slave      in_tvalid, in_tready, in_tdata, in_tuser      one arc per transfer
// out      master     out_tvalid, out_tready, out_tdata, out_tlast  one vertex per transfer
//
// An arc is walked depth-first: every bisection runs evaluate, two axes of
// seven steps on the shared 24x25 multiplier, and push; every leaf or empty
// segment is evaluated once; accept and the final vertex complete the arc.
// in_tready is high only while the sequencer is idle.
// Reset (rst_n low, synchronous) clears the sequencer and the output valid.
// A stalled output holds the sequencer only when a new vertex must go out.
module conic_arc_polyline_subdivider_unit
  import caps_pkg::*;
#(
  parameter int MAX_LEVELS = 5
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // start_x[23:0], start_y[47:24], end_x[71:48], end_y[95:72],
  // m_xx[115:96], m_xy[135:116], m_yx[155:136], m_yy[175:156]
  input  wire logic [175:0] in_tdata,
  // arc_kind[0]
  input  wire logic         in_tuser,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // vertex_x[23:0], vertex_y[47:24]
  output logic [47:0]       out_tdata,
  output logic              out_tlast
);

  localparam int SP_W  = $clog2(MAX_LEVELS + 1);
  localparam int IDX_W = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;

  // Sequencer and stack pointer.
  state_t           state_r, state_nxt;
  mstep_t           st_r;
  logic             axis_r;
  logic [SP_W-1:0]  sp_r;
  logic [SP_W-1:0]  sp_dec;

  // Arc inputs held for the whole arc.
  coord_t           e0x_r, e0y_r;
  mat_t             mxx_r, mxy_r, myx_r, myy_r;
  logic             kind_r;

  // Current segment and the stack of right halves still to visit.
  coord_t           cur_sx_r, cur_sy_r, cur_ex_r, cur_ey_r;
  lvl_t             cur_lv_r;
  coord_t           stk_sx_r [MAX_LEVELS];
  coord_t           stk_sy_r [MAX_LEVELS];
  coord_t           stk_ex_r [MAX_LEVELS];
  coord_t           stk_ey_r [MAX_LEVELS];
  lvl_t             stk_lv_r [MAX_LEVELS];

  // Bisection datapath.
  logic signed [24:0] vx, vy;
  logic signed [24:0] vx_r, vy_r;
  coord_t           pmx_r, pmy_r, pbx_r, pby_r;
  logic signed [23:0] mul_a;
  logic signed [24:0] mul_b;
  logic signed [48:0] prod_r;
  logic signed [45:0] acc_r;
  logic [55:0]      tsum_r;
  factor_t          factor;
  mat_t             m0, m1;

  // Pending vertex and output register.
  coord_t           pend_x_r, pend_y_r;
  logic             pend_vld_r;
  logic             out_valid_r;
  coord_t           out_x_r, out_y_r;
  logic             out_last_r;

  // Control strobes.
  logic             slot_free, seg_zero, seg_leaf;
  logic             ld_in, set_pend, emit_pend, do_pop, start_mul, do_push, ld_final;

  assign slot_free = !out_valid_r || out_tready;
  assign seg_zero  = (cur_sx_r == cur_ex_r) && (cur_sy_r == cur_ey_r);
  assign seg_leaf  = !seg_zero && (cur_lv_r >= LVL_W'(MAX_LEVELS));
  assign sp_dec    = sp_r - SP_W'(1);

  assign vx = {cur_ex_r[23], cur_ex_r} - {cur_sx_r[23], cur_sx_r};
  assign vy = {cur_ey_r[23], cur_ey_r} - {cur_sy_r[23], cur_sy_r};

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_y_r, out_x_r};
  assign out_tlast  = out_last_r;

  // Next state and strobes.
  always_comb begin
    state_nxt = state_r;
    ld_in     = 1'b0;
    set_pend  = 1'b0;
    emit_pend = 1'b0;
    do_pop    = 1'b0;
    start_mul = 1'b0;
    do_push   = 1'b0;
    ld_final  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          ld_in     = 1'b1;
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        if (seg_zero || seg_leaf) begin
          if (!(seg_leaf && pend_vld_r && !slot_free)) begin
            set_pend  = seg_leaf;
            emit_pend = seg_leaf && pend_vld_r;
            if (sp_r != '0) begin
              do_pop = 1'b1;
            end else begin
              state_nxt = S_DONE;
            end
          end
        end else begin
          start_mul = 1'b1;
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        if (st_r == MS_ADD && axis_r) begin
          state_nxt = S_PUSH;
        end
      end
      S_PUSH: begin
        do_push   = 1'b1;
        state_nxt = S_EVAL;
      end
      S_DONE: begin
        if (slot_free) begin
          ld_final  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Control registers: stack pointer, multiply step, pending flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sp_r       <= '0;
      st_r       <= MS_P0;
      axis_r     <= 1'b0;
      pend_vld_r <= 1'b0;
    end else begin
      if (ld_in) begin
        sp_r       <= '0;
        pend_vld_r <= 1'b0;
      end else if (do_pop) begin
        sp_r <= sp_dec;
      end else if (do_push) begin
        sp_r <= sp_r + SP_W'(1);
      end
      if (set_pend) begin
        pend_vld_r <= 1'b1;
      end
      if (start_mul) begin
        st_r   <= MS_P0;
        axis_r <= 1'b0;
      end else if (state_r == S_MUL) begin
        if (st_r == MS_ADD) begin
          st_r   <= MS_P0;
          axis_r <= 1'b1;
        end else begin
          st_r <= mstep_t'(st_r + 3'd1);
        end
      end
    end
  end

  // Shared multiplier operand selection.
  assign m0     = axis_r ? myx_r : mxx_r;
  assign m1     = axis_r ? myy_r : mxy_r;
  assign factor = chord_factor(kind_r, cur_lv_r);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (st_r)
      MS_P0: begin
        mul_a = {{4{m0[19]}}, m0};
        mul_b = vx_r;
      end
      MS_P1: begin
        mul_a = {{4{m1[19]}}, m1};
        mul_b = vy_r;
      end
      MS_FLO: begin
        mul_a = {1'b0, acc_r[22:0]};
        mul_b = {9'd0, factor};
      end
      MS_FHI: begin
        mul_a = {acc_r[45], acc_r[45:23]};
        mul_b = {9'd0, factor};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Multiply, accumulate and bisection point.
  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
    if (start_mul) begin
      vx_r  <= vx;
      vy_r  <= vy;
      pmx_r <= cur_sx_r + vx[24:1];
      pmy_r <= cur_sy_r + vy[24:1];
    end
    if (state_r == S_MUL) begin
      case (st_r)
        MS_P1:  acc_r  <= prod_r[45:0];
        MS_SUM: acc_r  <= acc_r + prod_r[45:0];
        MS_FHI: tsum_r <= {16'd0, prod_r[39:0]} + 56'h0000_0080_000000;
        MS_ACC: tsum_r <= tsum_r + {prod_r[32:0], 23'd0};
        MS_ADD: begin
          if (axis_r) begin
            pby_r <= pmy_r + tsum_r[55:32];
          end else begin
            pbx_r <= pmx_r + tsum_r[55:32];
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Current segment, stack and pending vertex.
  always_ff @(posedge clk) begin
    if (ld_in) begin
      cur_sx_r <= in_tdata[23:0];
      cur_sy_r <= in_tdata[47:24];
      cur_ex_r <= in_tdata[71:48];
      cur_ey_r <= in_tdata[95:72];
      cur_lv_r <= '0;
      e0x_r    <= in_tdata[71:48];
      e0y_r    <= in_tdata[95:72];
      mxx_r    <= in_tdata[115:96];
      mxy_r    <= in_tdata[135:116];
      myx_r    <= in_tdata[155:136];
      myy_r    <= in_tdata[175:156];
      kind_r   <= in_tuser;
    end else if (do_pop) begin
      cur_sx_r <= stk_sx_r[sp_dec[IDX_W-1:0]];
      cur_sy_r <= stk_sy_r[sp_dec[IDX_W-1:0]];
      cur_ex_r <= stk_ex_r[sp_dec[IDX_W-1:0]];
      cur_ey_r <= stk_ey_r[sp_dec[IDX_W-1:0]];
      cur_lv_r <= stk_lv_r[sp_dec[IDX_W-1:0]];
    end else if (do_push) begin
      // Keep the left half as current; save the right half.
      cur_ex_r <= pbx_r;
      cur_ey_r <= pby_r;
      cur_lv_r <= cur_lv_r + LVL_W'(1);
      stk_sx_r[sp_r[IDX_W-1:0]] <= pbx_r;
      stk_sy_r[sp_r[IDX_W-1:0]] <= pby_r;
      stk_ex_r[sp_r[IDX_W-1:0]] <= cur_ex_r;
      stk_ey_r[sp_r[IDX_W-1:0]] <= cur_ey_r;
      stk_lv_r[sp_r[IDX_W-1:0]] <= cur_lv_r + LVL_W'(1);
    end
    if (set_pend) begin
      pend_x_r <= cur_ex_r;
      pend_y_r <= cur_ey_r;
    end
  end

  // Output register: one vertex is held back until the next is known.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit_pend || ld_final) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_pend || ld_final) begin
      out_x_r    <= (ld_final && !pend_vld_r) ? e0x_r : pend_x_r;
      out_y_r    <= (ld_final && !pend_vld_r) ? e0y_r : pend_y_r;
      out_last_r <= ld_final;
    end
  end

  // Checks on the sequencer.
  a_sp_bound: assert property (@(posedge clk) disable iff (!rst_n)
    sp_r <= SP_W'(MAX_LEVELS))
    else $error("segment stack pointer beyond depth");

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PUSH) |-> (sp_r < SP_W'(MAX_LEVELS)))
    else $error("push into a full segment stack");

  a_mul_level: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MUL) |-> (cur_lv_r < LVL_W'(MAX_LEVELS)))
    else $error("bisection at the maximum level");

  a_accept_eval: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (state_r == S_EVAL && sp_r == '0 && !pend_vld_r))
    else $error("arc accepted without a fresh traversal");

  a_final_last: assert property (@(posedge clk) disable iff (!rst_n)
    ld_final |=> (out_tvalid && out_tlast && state_r == S_IDLE))
    else $error("final vertex not marked last");

endmodule

`default_nettype wire

// ===== test/conic_arc_polyline_subdivider_unit_test.sv =====
`timescale 1ns / 1ps

module conic_arc_polyline_subdivider_unit_test;
  import caps_pkg::*;

  localparam int LEVELS         = 5;
  localparam int STACK_ENTRIES  = LEVELS + 1;
  localparam int MAX_VERTICES   = 32;
  localparam int STALL_LIMIT    = 4000;
  localparam int DRAIN_CYCLES   = 600;
  localparam int HOLDOFF_CYCLES = 400;
  localparam int UNIT_GAIN      = 65536;

  typedef struct packed {
    coord_t sx;
    coord_t sy;
    coord_t ex;
    coord_t ey;
    logic   kind;
    mat_t   mxx;
    mat_t   mxy;
    mat_t   myx;
    mat_t   myy;
  } arc_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    logic   last;
  } vertex_t;

  logic         clk = 1'b0;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [175:0] in_tdata;
  logic         in_tuser;
  logic         out_tvalid;
  logic         out_tready;
  logic [47:0]  out_tdata;
  logic         out_tlast;

  vertex_t expected_vertices[$];
  int      vertex_mismatches = 0;
  int      quiet_cycles = 0;
  int      holdoff_request = 0;
  bit      idling_enabled = 1'b1;

  conic_arc_polyline_subdivider_unit #(
    .MAX_LEVELS(LEVELS)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

  // Free-running clock, 8 ns period.
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic longint coord_value(input coord_t c);
    return longint'(c);
  endfunction

  function automatic longint mat_value(input mat_t m);
    return longint'(m);
  endfunction

  // Bring a value back into 24-bit two's complement.
  function automatic longint wrap_coord(input longint v);
    coord_t c;
    c = v[COORD_W-1:0];
    return longint'(c);
  endfunction

  // Chord factor, 0.5*tan(angle/4) in 16 fraction bits. A half arc is the
  // quarter sequence moved one level deeper, with 0.5 in front.
  function automatic longint chord_gain(input logic kind, input int level);
    int lv;
    lv = (level > 5) ? 5 : level;
    if (kind == KIND_HALF) begin
      if (lv == 0) return 32768;
      lv = lv - 1;
    end
    case (lv)
      0:       return 13573;
      1:       return 6518;
      2:       return 3227;
      3:       return 1610;
      4:       return 804;
      default: return 402;
    endcase
  endfunction

  // Walk the bisection tree depth-first and queue the vertices it yields.
  task automatic predict_polyline(input arc_t a);
    longint  seg_sx[STACK_ENTRIES];
    longint  seg_sy[STACK_ENTRIES];
    longint  seg_ex[STACK_ENTRIES];
    longint  seg_ey[STACK_ENTRIES];
    int      seg_lvl[STACK_ENTRIES];
    longint  vert_x[MAX_VERTICES];
    longint  vert_y[MAX_VERTICES];
    longint  mxx, mxy, myx, myy;
    longint  chord_x, chord_y, mid_x, mid_y, gain, lean_x, lean_y, bis_x, bis_y;
    longint  round_half;
    int      top;
    int      count;
    vertex_t v;
    round_half = longint'(1) <<< 31;
    mxx = mat_value(a.mxx);
    mxy = mat_value(a.mxy);
    myx = mat_value(a.myx);
    myy = mat_value(a.myy);
    seg_sx[0] = coord_value(a.sx);
    seg_sy[0] = coord_value(a.sy);
    seg_ex[0] = coord_value(a.ex);
    seg_ey[0] = coord_value(a.ey);
    seg_lvl[0] = 0;
    top = 0;
    count = 0;
    while (top >= 0) begin
      if (seg_sx[top] == seg_ex[top] && seg_sy[top] == seg_ey[top]) begin
        // Zero-length segment: dropped silently.
        top--;
      end else if (seg_lvl[top] >= LEVELS) begin
        vert_x[count] = seg_ex[top];
        vert_y[count] = seg_ey[top];
        count++;
        top--;
      end else begin
        chord_x = seg_ex[top] - seg_sx[top];
        chord_y = seg_ey[top] - seg_sy[top];
        mid_x = seg_sx[top] + (chord_x >>> 1);
        mid_y = seg_sy[top] + (chord_y >>> 1);
        gain = chord_gain(a.kind, seg_lvl[top]);
        lean_x = (mxx * chord_x + mxy * chord_y) * gain;
        lean_y = (myx * chord_x + myy * chord_y) * gain;
        bis_x = wrap_coord(mid_x + ((lean_x + round_half) >>> 32));
        bis_y = wrap_coord(mid_y + ((lean_y + round_half) >>> 32));
        // The first half goes on top, the second half stays below it.
        seg_sx[top + 1] = seg_sx[top];
        seg_sy[top + 1] = seg_sy[top];
        seg_ex[top + 1] = bis_x;
        seg_ey[top + 1] = bis_y;
        seg_lvl[top + 1] = seg_lvl[top] + 1;
        seg_sx[top] = bis_x;
        seg_sy[top] = bis_y;
        seg_lvl[top] = seg_lvl[top] + 1;
        top++;
      end
    end
    // An arc that yields nothing still emits its end point.
    if (count == 0) begin
      vert_x[0] = coord_value(a.ex);
      vert_y[0] = coord_value(a.ey);
      count = 1;
    end
    for (int k = 0; k < count; k++) begin
      v.x = vert_x[k][COORD_W-1:0];
      v.y = vert_y[k][COORD_W-1:0];
      v.last = (k == count - 1);
      expected_vertices.push_back(v);
    end
  endtask

  function automatic arc_t make_arc(input int sx, input int sy, input int ex, input int ey,
                                    input logic kind, input int mxx, input int mxy,
                                    input int myx, input int myy);
    arc_t a;
    a.sx = sx[COORD_W-1:0];
    a.sy = sy[COORD_W-1:0];
    a.ex = ex[COORD_W-1:0];
    a.ey = ey[COORD_W-1:0];
    a.kind = kind;
    a.mxx = mxx[MAT_W-1:0];
    a.mxy = mxy[MAT_W-1:0];
    a.myx = myx[MAT_W-1:0];
    a.myy = myy[MAT_W-1:0];
    return a;
  endfunction

  function automatic int small_noise(input int span);
    return int'($urandom_range(0, 2 * span)) - span;
  endfunction

  // Random arc drawn from a mix of shapes: raw fields, circle-like arcs
  // with a rotation matrix, tiny chords, degenerate chords and straight
  // lines with a zero matrix.
  function automatic arc_t random_arc();
    arc_t a;
    int   shape;
    int   reach;
    int   turn;
    shape = $urandom_range(0, 9);
    a = make_arc($urandom, $urandom, $urandom, $urandom, 1'($urandom_range(0, 1)),
                 $urandom, $urandom, $urandom, $urandom);
    if (shape >= 3 && shape <= 6) begin
      reach = 1 << $urandom_range(0, 20);
      turn = $urandom_range(0, 1) ? UNIT_GAIN : -UNIT_GAIN;
      a.ex = coord_t'(coord_value(a.sx) + small_noise(reach));
      a.ey = coord_t'(coord_value(a.sy) + small_noise(reach));
      a.mxx = mat_t'(small_noise(64));
      a.mxy = mat_t'(-turn + small_noise(64));
      a.myx = mat_t'(turn + small_noise(64));
      a.myy = mat_t'(small_noise(64));
    end else if (shape == 7) begin
      a.ex = coord_t'(coord_value(a.sx) + small_noise(3));
      a.ey = coord_t'(coord_value(a.sy) + small_noise(3));
      if ($urandom_range(0, 1)) begin
        a.mxx = '0;
        a.mxy = '0;
        a.myx = '0;
        a.myy = '0;
      end
    end else if (shape == 8) begin
      a.ex = a.sx;
      a.ey = a.sy;
    end else if (shape == 9) begin
      a.mxx = '0;
      a.mxy = '0;
      a.myx = '0;
      a.myy = '0;
    end
    return a;
  endfunction

  // Offer one arc, with an optional idle gap first, and predict it once the
  // transfer takes place.
  task automatic send_arc(input arc_t a);
    if (idling_enabled && $urandom_range(0, 3) == 0) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 9) - 1) @(negedge clk);
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata <= {a.myy, a.myx, a.mxy, a.mxx, a.ey, a.ex, a.sy, a.sx};
    in_tuser <= a.kind;
    do @(posedge clk); while (!in_tready);
    predict_polyline(a);
  endtask

  task automatic note_mismatch(input string what);
    vertex_mismatches++;
    if (vertex_mismatches <= 10) $display("%t: %s", $realtime, what);
  endtask

  // Result checker: every vertex transfer against the oldest prediction.
  always @(posedge clk) begin
    vertex_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_vertices.size() == 0) begin
        note_mismatch($sformatf("unexpected vertex x=%h y=%h last=%b",
                                out_tdata[23:0], out_tdata[47:24], out_tlast));
      end else begin
        want = expected_vertices.pop_front();
        if (out_tdata[23:0] !== want.x || out_tdata[47:24] !== want.y ||
            out_tlast !== want.last) begin
          note_mismatch($sformatf("vertex expected x=%h y=%h last=%b, got x=%h y=%h last=%b",
                                  want.x, want.y, want.last, out_tdata[23:0],
                                  out_tdata[47:24], out_tlast));
        end
      end
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("conic_arc_polyline_subdivider_unit test failed");
        $finish;
      end
    end
  end

  // Vertex receiver: random stall bursts, or one long hold-off on request.
  initial begin
    int hold;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (holdoff_request > 0) begin
        hold = holdoff_request;
        holdoff_request = 0;
        out_tready <= 1'b0;
        repeat (hold) @(negedge clk);
      end else if (idling_enabled && $urandom_range(0, 3) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 9) - 1) @(negedge clk);
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Equal endpoints at the origin and at both corners of the range.
  task automatic test_degenerate_chords();
    send_arc(make_arc(0, 0, 0, 0, KIND_QUARTER, 0, -UNIT_GAIN, UNIT_GAIN, 0));
    send_arc(make_arc(8388607, 8388607, 8388607, 8388607, KIND_HALF,
                      524287, 524287, -524288, -524288));
    send_arc(make_arc(-8388608, -8388608, -8388608, -8388608, KIND_QUARTER,
                      $urandom, $urandom, $urandom, $urandom));
  endtask

  // Chords across the whole coordinate range, with and without bulge.
  task automatic test_coordinate_extremes();
    send_arc(make_arc(-8388608, -8388608, 8388607, 8388607, KIND_QUARTER, 0, 0, 0, 0));
    send_arc(make_arc(8388607, -8388608, -8388608, 8388607, KIND_HALF,
                      0, -UNIT_GAIN, UNIT_GAIN, 0));
    send_arc(make_arc(8388607, 8388607, -8388608, -8388608, KIND_QUARTER,
                      524287, -524288, 524287, -524288));
    send_arc(make_arc(-8388608, 8388607, 8388607, -8388608, KIND_HALF,
                      -524288, -524288, -524288, -524288));
  endtask

  // Largest matrix entries, where bisection points wrap around.
  task automatic test_matrix_extremes();
    send_arc(make_arc(1000000, -2000000, -3000000, 4000000, KIND_QUARTER,
                      524287, 524287, 524287, 524287));
    send_arc(make_arc(1000000, -2000000, -3000000, 4000000, KIND_HALF,
                      -524288, -524288, -524288, -524288));
    send_arc(make_arc(-5000, 7000, 6000000, -6000000, KIND_HALF,
                      524287, -524288, -524288, 524287));
    send_arc(make_arc(300, 400, -300, -400, KIND_QUARTER,
                      -524288, 524287, 524287, -524288));
  endtask

  // Genuine circular arcs in both turning senses and both kinds.
  task automatic test_circular_arcs();
    send_arc(make_arc(25600, 0, 0, 25600, KIND_QUARTER, 0, -UNIT_GAIN, UNIT_GAIN, 0));
    send_arc(make_arc(25600, 0, 0, -25600, KIND_QUARTER, 0, UNIT_GAIN, -UNIT_GAIN, 0));
    send_arc(make_arc(25600, 0, -25600, 0, KIND_HALF, 0, -UNIT_GAIN, UNIT_GAIN, 0));
    send_arc(make_arc(-1280, 640, 1280, -640, KIND_HALF, 0, UNIT_GAIN, -UNIT_GAIN, 0));
  endtask

  // Chords of a few units, where most sub-segments collapse to zero length, and a full-width chord one unit high.
  task automatic test_tiny_chords();
    send_arc(make_arc(0, 0, 1, 0, KIND_QUARTER, 0, 0, 0, 0));
    send_arc(make_arc(5, 5, 5, 4, KIND_HALF, 0, 0, 0, 0));
    send_arc(make_arc(-1, -1, 0, 0, KIND_QUARTER, 0, 0, 0, 0));
    send_arc(make_arc(10, 20, 12, 17, KIND_HALF, 0, -UNIT_GAIN, UNIT_GAIN, 0));
    send_arc(make_arc(-8388608, 0, 8388607, 1, KIND_QUARTER, 0, 0, 0, 0));
  endtask

  task automatic test_random_arcs(input int count);
    repeat (count) send_arc(random_arc());
  endtask

  // Hold the receiver off for a long stretch while arcs keep coming.
  task automatic test_output_backpressure();
    holdoff_request = HOLDOFF_CYCLES;
    repeat (6) send_arc(random_arc());
  endtask

  // Back-to-back arcs with no idling on either side.
  task automatic test_steady_stream(input int count);
    idling_enabled = 1'b0;
    repeat (count) send_arc(random_arc());
  endtask

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_degenerate_chords();
    test_coordinate_extremes();
    test_matrix_extremes();
    test_circular_arcs();
    test_tiny_chords();
    test_random_arcs(220);
    test_output_backpressure();
    test_random_arcs(220);
    test_steady_stream(60);

    @(negedge clk);
    in_tvalid <= 1'b0;
    while (expected_vertices.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (vertex_mismatches == 0) begin
      $display("conic_arc_polyline_subdivider_unit test passed");
    end else begin
      $display("conic_arc_polyline_subdivider_unit test failed");
    end
    $finish;
  end

endmodule
